/* hw/rtl/plf_pkg.sv */
// shared types and constants for the playfair digraph cipher
package plf_pkg;

    localparam int unsigned LETTER_W    = 5;
    localparam int unsigned SIDE        = 5;
    localparam int unsigned CELLS       = 25;
    localparam int unsigned LETTERS     = 26;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] CMD_START_KEY  = 3'd0;
    localparam logic [2:0] CMD_KEY_CHAR   = 3'd1;
    localparam logic [2:0] CMD_CLOSE_KEY  = 3'd2;
    localparam logic [2:0] CMD_PLAIN_CHAR = 3'd3;
    localparam logic [2:0] CMD_END_MSG    = 3'd4;

    localparam logic [LETTER_W-1:0] IDX_I = 5'd8;
    localparam logic [LETTER_W-1:0] IDX_J = 5'd9;
    localparam logic [LETTER_W-1:0] IDX_X = 5'd23;
    localparam logic [6:0]          ASCII_A = 7'd65;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] character;
    } item_t;

    typedef struct packed {
        logic [6:0] cipher_letter;
        logic       last_of_run;
        logic       message_done;
    } result_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_KEY,
        OP_CLOSE,
        OP_PAIR
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                done;
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WALK,
        BK_LOOKUP,
        BK_EMIT_FIRST,
        BK_EMIT_SECOND
    } back_state_t;

endpackage

/* hw/rtl/plf_front.sv */
// front end: letter decode, digraph pairing and operation issue
module plf_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  plf_pkg::item_t item,
    input  logic           queue_full,
    output logic           push,
    output plf_pkg::op_t   push_op
);

    logic [plf_pkg::LETTER_W-1:0] held_letter_reg;
    logic [plf_pkg::LETTER_W-1:0] held_letter_next;
    logic                         held_valid_reg;
    logic                         held_valid_next;
    logic                         is_letter;
    logic [plf_pkg::LETTER_W-1:0] raw_idx;
    logic [plf_pkg::LETTER_W-1:0] idx;
    logic                         accept;
    logic                         want_push;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign push       = accept && want_push;

    // upper and lower case fold together, j folds onto i
    always_comb
    begin
        is_letter = 1'b0;
        raw_idx   = '0;
        if (item.character inside {[8'd65:8'd90]})
        begin
            is_letter = 1'b1;
            raw_idx   = plf_pkg::LETTER_W'(item.character - 8'd65);
        end
        else if (item.character inside {[8'd97:8'd122]})
        begin
            is_letter = 1'b1;
            raw_idx   = plf_pkg::LETTER_W'(item.character - 8'd97);
        end
        idx = (raw_idx == plf_pkg::IDX_J) ? plf_pkg::IDX_I : raw_idx;
    end

    always_comb
    begin
        want_push        = 1'b0;
        push_op.kind     = plf_pkg::OP_START;
        push_op.first    = idx;
        push_op.second   = idx;
        push_op.done     = 1'b0;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        case (item.command)
            plf_pkg::CMD_START_KEY:
            begin
                want_push       = 1'b1;
                push_op.kind    = plf_pkg::OP_START;
                held_valid_next = 1'b0;
            end
            plf_pkg::CMD_KEY_CHAR:
            begin
                want_push    = is_letter;
                push_op.kind = plf_pkg::OP_KEY;
            end
            plf_pkg::CMD_CLOSE_KEY:
            begin
                want_push    = 1'b1;
                push_op.kind = plf_pkg::OP_CLOSE;
            end
            plf_pkg::CMD_PLAIN_CHAR:
            begin
                if (is_letter)
                begin
                    if (!held_valid_reg)
                    begin
                        held_letter_next = idx;
                        held_valid_next  = 1'b1;
                    end
                    else
                    begin
                        want_push     = 1'b1;
                        push_op.kind  = plf_pkg::OP_PAIR;
                        push_op.first = held_letter_reg;
                        // doubled letter: pad with x and keep the letter held
                        if (idx == held_letter_reg)
                        begin
                            push_op.second = plf_pkg::IDX_X;
                        end
                        else
                        begin
                            push_op.second  = idx;
                            held_valid_next = 1'b0;
                        end
                    end
                end
            end
            plf_pkg::CMD_END_MSG:
            begin
                if (held_valid_reg)
                begin
                    want_push       = 1'b1;
                    push_op.kind    = plf_pkg::OP_PAIR;
                    push_op.first   = held_letter_reg;
                    push_op.second  = plf_pkg::IDX_X;
                    push_op.done    = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
        end
        else if (accept)
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
        end
    end

endmodule

/* hw/rtl/plf_queue.sv */
// operation queue between front end and back end
module plf_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  plf_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output plf_pkg::op_t head_op
);

    plf_pkg::op_t                    slot_reg [plf_pkg::QUEUE_DEPTH];
    logic [plf_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [plf_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [plf_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [plf_pkg::QUEUE_CNT_W-1:0] count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full       = (count_reg == plf_pkg::QUEUE_CNT_W'(plf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == plf_pkg::QUEUE_PTR_W'(plf_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == plf_pkg::QUEUE_PTR_W'(plf_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* hw/rtl/plf_back.sv */
// back end: key square build, pair lookup and cipher word output
module plf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  plf_pkg::op_t     head_op,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output plf_pkg::result_t result
);

    localparam int unsigned LW = plf_pkg::LETTER_W;

    logic [LW-1:0] square_mem [plf_pkg::CELLS];
    logic [LW-1:0] position_mem [plf_pkg::LETTERS];

    plf_pkg::back_state_t state_reg;
    plf_pkg::back_state_t state_next;

    logic [plf_pkg::LETTERS-1:0] seen_reg;
    logic [plf_pkg::LETTERS-1:0] seen_next;
    logic [LW-1:0]               fill_reg;
    logic [LW-1:0]               fill_next;
    logic [LW-1:0]               walk_reg;
    logic [LW-1:0]               walk_next;
    logic                        done_reg;
    logic                        done_next;

    logic [LW-1:0] pos_a_reg;
    logic [LW-1:0] pos_b_reg;
    logic [LW-1:0] sq_a_reg;
    logic [LW-1:0] sq_b_reg;

    logic                result_valid_reg;
    logic                result_valid_next;
    plf_pkg::result_t    result_reg;
    plf_pkg::result_t    result_next;
    logic                result_load;

    logic          place_en;
    logic [LW-1:0] place_letter;
    logic          pos_rd_en;
    logic          sq_rd_en;
    logic [LW-1:0] cell_a;
    logic [LW-1:0] cell_b;
    logic [2:0]    row_a;
    logic [2:0]    col_a;
    logic [2:0]    row_b;
    logic [2:0]    col_b;
    logic          out_free;

    function automatic logic [5:0] split_pos(input logic [LW-1:0] pos);
        logic [2:0] row;
        logic [LW-1:0] rest;
        begin
            if (pos >= 5'd20)
            begin
                row  = 3'd4;
                rest = pos - 5'd20;
            end
            else if (pos >= 5'd15)
            begin
                row  = 3'd3;
                rest = pos - 5'd15;
            end
            else if (pos >= 5'd10)
            begin
                row  = 3'd2;
                rest = pos - 5'd10;
            end
            else if (pos >= 5'd5)
            begin
                row  = 3'd1;
                rest = pos - 5'd5;
            end
            else
            begin
                row  = 3'd0;
                rest = pos;
            end
            split_pos = {row, rest[2:0]};
        end
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        wrap_inc = (v == 3'(plf_pkg::SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [LW-1:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        cell_of = LW'({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
    endfunction

    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        {row_a, col_a} = split_pos(pos_a_reg);
        {row_b, col_b} = split_pos(pos_b_reg);
        if (row_a == row_b)
        begin
            cell_a = cell_of(row_a, wrap_inc(col_a));
            cell_b = cell_of(row_b, wrap_inc(col_b));
        end
        else if (col_a == col_b)
        begin
            cell_a = cell_of(wrap_inc(row_a), col_a);
            cell_b = cell_of(wrap_inc(row_b), col_b);
        end
        else
        begin
            cell_a = cell_of(row_a, col_b);
            cell_b = cell_of(row_b, col_a);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        seen_next    = seen_reg;
        fill_next    = fill_reg;
        walk_next    = walk_reg;
        done_next    = done_reg;
        pop          = 1'b0;
        place_en     = 1'b0;
        place_letter = head_op.first;
        pos_rd_en    = 1'b0;
        sq_rd_en     = 1'b0;
        result_load  = 1'b0;
        result_next  = result_reg;
        case (state_reg)
            plf_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head_op.kind)
                        plf_pkg::OP_START:
                        begin
                            seen_next = '0;
                            fill_next = '0;
                        end
                        plf_pkg::OP_KEY:
                        begin
                            place_letter = head_op.first;
                            place_en     = !seen_reg[head_op.first]
                                           && (fill_reg < LW'(plf_pkg::CELLS));
                        end
                        plf_pkg::OP_CLOSE:
                        begin
                            walk_next  = '0;
                            state_next = plf_pkg::BK_WALK;
                        end
                        plf_pkg::OP_PAIR:
                        begin
                            pos_rd_en  = 1'b1;
                            done_next  = head_op.done;
                            state_next = plf_pkg::BK_LOOKUP;
                        end
                        default:
                        begin
                            state_next = plf_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            plf_pkg::BK_WALK:
            begin
                // one alphabet letter per cycle, j never enters the square
                place_letter = walk_reg;
                place_en     = (walk_reg != plf_pkg::IDX_J) && !seen_reg[walk_reg]
                               && (fill_reg < LW'(plf_pkg::CELLS));
                walk_next    = walk_reg + 1'b1;
                if (walk_reg == LW'(plf_pkg::LETTERS - 1))
                begin
                    state_next = plf_pkg::BK_IDLE;
                end
            end
            plf_pkg::BK_LOOKUP:
            begin
                sq_rd_en   = 1'b1;
                state_next = plf_pkg::BK_EMIT_FIRST;
            end
            plf_pkg::BK_EMIT_FIRST:
            begin
                if (out_free)
                begin
                    result_load               = 1'b1;
                    result_next.cipher_letter = plf_pkg::ASCII_A + {2'b00, sq_a_reg};
                    result_next.last_of_run   = 1'b0;
                    result_next.message_done  = 1'b0;
                    state_next                = plf_pkg::BK_EMIT_SECOND;
                end
            end
            plf_pkg::BK_EMIT_SECOND:
            begin
                if (out_free)
                begin
                    result_load               = 1'b1;
                    result_next.cipher_letter = plf_pkg::ASCII_A + {2'b00, sq_b_reg};
                    result_next.last_of_run   = 1'b1;
                    result_next.message_done  = done_reg;
                    state_next                = plf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = plf_pkg::BK_IDLE;
            end
        endcase
        if (place_en)
        begin
            seen_next[place_letter] = 1'b1;
            fill_next               = fill_reg + 1'b1;
        end
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= plf_pkg::BK_IDLE;
            seen_reg         <= '0;
            fill_reg         <= '0;
            walk_reg         <= '0;
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seen_reg         <= seen_next;
            fill_reg         <= fill_next;
            walk_reg         <= walk_next;
            done_reg         <= done_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= result_next;
        end
    end

    // key square and letter position stores
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            square_mem[fill_reg]       <= place_letter;
            position_mem[place_letter] <= fill_reg;
        end
        if (pos_rd_en)
        begin
            pos_a_reg <= position_mem[head_op.first];
            pos_b_reg <= position_mem[head_op.second];
        end
        if (sq_rd_en)
        begin
            sq_a_reg <= square_mem[cell_a];
            sq_b_reg <= square_mem[cell_b];
        end
    end

endmodule

/* hw/rtl/playfair_digraph_cipher_top.sv */
// playfair digraph cipher: an enciphered pair passes the queue, position read, square read and result register
// a pair occupies the back end for a position read, a square read and two output words
// key letters and start key are handled in the back end's idle state; close key walks the alphabet
// a 2-entry operation queue lets input words keep flowing while the back end is busy, until it is full
// reset clears pairing, fill count and seen letters; square contents are undefined until keyed
module playfair_digraph_cipher_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  plf_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output plf_pkg::result_t result
);

    logic         push;
    plf_pkg::op_t push_op;
    logic         queue_full;
    logic         pop;
    logic         head_valid;
    plf_pkg::op_t head_op;

    plf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    plf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    plf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_op      (head_op),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* tb/sv/playfair_digraph_cipher_top_tb.sv */
// self-checking testbench for the playfair digraph cipher: keyed sessions, messages, random stalls
module playfair_digraph_cipher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PERIOD       = 20;
    localparam int unsigned IDLE_PCT     = 24;
    localparam int unsigned ITEMS        = 450;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;

    class cipher_scoreboard;
        logic [plf_pkg::LETTER_W-1:0] grid [plf_pkg::CELLS];
        logic [plf_pkg::LETTER_W-1:0] cell_of [plf_pkg::LETTERS];
        bit                           seen [plf_pkg::LETTERS];
        int unsigned                  filled;
        int unsigned                  held;
        bit                           held_v;
        plf_pkg::result_t             cipher_q [$];
        int unsigned                  errors;
        int unsigned                  words_in;
        int unsigned                  live_words;
        int unsigned                  letters_checked;
        int unsigned                  pairs_made;
        int unsigned                  keys_closed;

        function int letter_code(logic [7:0] c);
            int v;
            if (c >= "A" && c <= "Z")
                v = c - "A";
            else if (c >= "a" && c <= "z")
                v = c - "a";
            else
                return -1;
            if (v == plf_pkg::IDX_J)
                v = plf_pkg::IDX_I;
            return v;
        endfunction

        function void place(int unsigned l);
            if (filled < plf_pkg::CELLS)
            begin
                grid[filled] = plf_pkg::LETTER_W'(l);
                cell_of[l]   = plf_pkg::LETTER_W'(filled);
                seen[l]      = 1'b1;
                filled++;
            end
        endfunction

        function logic [6:0] cell_at(int unsigned r, int unsigned c);
            return plf_pkg::ASCII_A
                   + 7'(grid[(r % plf_pkg::SIDE) * plf_pkg::SIDE + (c % plf_pkg::SIDE)]);
        endfunction

        function void encipher(int unsigned a, int unsigned b, bit done);
            int unsigned      pa, pb, r1, c1, r2, c2;
            plf_pkg::result_t w1, w2;
            pa = cell_of[a];
            pb = cell_of[b];
            r1 = pa / plf_pkg::SIDE;
            c1 = pa % plf_pkg::SIDE;
            r2 = pb / plf_pkg::SIDE;
            c2 = pb % plf_pkg::SIDE;
            if (r1 == r2)
            begin
                w1.cipher_letter = cell_at(r1, c1 + 1);
                w2.cipher_letter = cell_at(r2, c2 + 1);
            end
            else if (c1 == c2)
            begin
                w1.cipher_letter = cell_at(r1 + 1, c1);
                w2.cipher_letter = cell_at(r2 + 1, c2);
            end
            else
            begin
                w1.cipher_letter = cell_at(r1, c2);
                w2.cipher_letter = cell_at(r2, c1);
            end
            w1.last_of_run  = 1'b0;
            w1.message_done = 1'b0;
            w2.last_of_run  = 1'b1;
            w2.message_done = done;
            cipher_q.push_back(w1);
            cipher_q.push_back(w2);
            pairs_made++;
        endfunction

        function void note_input(plf_pkg::item_t w);
            int l;
            l = letter_code(w.character);
            words_in++;
            if (w.command <= plf_pkg::CMD_END_MSG &&
                !((w.command == plf_pkg::CMD_KEY_CHAR || w.command == plf_pkg::CMD_PLAIN_CHAR)
                  && l < 0))
                live_words++;
            case (w.command)
                plf_pkg::CMD_START_KEY:
                begin
                    foreach (seen[k])
                        seen[k] = 1'b0;
                    filled = 0;
                    held_v = 1'b0;
                end
                plf_pkg::CMD_KEY_CHAR:
                    if (l >= 0 && !seen[l])
                        place(l);
                plf_pkg::CMD_CLOSE_KEY:
                begin
                    for (int k = 0; k < plf_pkg::LETTERS; k++)
                        if (k != plf_pkg::IDX_J && !seen[k])
                            place(k);
                    keys_closed++;
                end
                plf_pkg::CMD_PLAIN_CHAR:
                    if (l >= 0)
                    begin
                        if (!held_v)
                        begin
                            held   = l;
                            held_v = 1'b1;
                        end
                        // doubled letter: pad with X, the repeat opens the next pair
                        else if (l == held)
                            encipher(held, plf_pkg::IDX_X, 1'b0);
                        else
                        begin
                            encipher(held, l, 1'b0);
                            held_v = 1'b0;
                        end
                    end
                plf_pkg::CMD_END_MSG:
                    if (held_v)
                    begin
                        encipher(held, plf_pkg::IDX_X, 1'b1);
                        held_v = 1'b0;
                    end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(plf_pkg::result_t r);
            plf_pkg::result_t want;
            if (cipher_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual letter %0d",
                         $time, r.cipher_letter);
                return;
            end
            want = cipher_q.pop_front();
            compare_field("cipher_letter", want.cipher_letter, r.cipher_letter);
            compare_field("last_of_run", want.last_of_run, r.last_of_run);
            compare_field("message_done", want.message_done, r.message_done);
            letters_checked++;
        endfunction

        function int unsigned pending();
            return cipher_q.size();
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    plf_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    plf_pkg::result_t result;

    logic        calm = 1'b0;
    int unsigned stall_cycles = 0;
    logic [7:0]  last_plain = "X";

    cipher_scoreboard sb = new();

    playfair_digraph_cipher_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // results are checked before the input of the same edge is noted
    always @(posedge clk)
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_result(result);
            if (item_valid && item_ready)
                sb.note_input(item);
        end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_word(input logic [2:0] cmd, input logic [7:0] ch);
        plf_pkg::item_t w;
        w.command   = cmd;
        w.character = ch;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(1) ? "a" : "A") + 8'($urandom_range(0, plf_pkg::LETTERS - 1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_message(input int unsigned len);
        int unsigned r;
        logic [7:0]  ch;
        for (int k = 0; k < len; k++)
        begin
            r = $urandom_range(99);
            if (r < 60 || r >= 75 && r < 83)
            begin
                ch = (r < 60) ? rand_letter() : 8'(plf_pkg::ASCII_A + plf_pkg::IDX_X);
                last_plain = ch;
                send_word(plf_pkg::CMD_PLAIN_CHAR, ch);
            end
            else if (r < 75)
                // repeat the previous letter, sometimes in the other case
                send_word(plf_pkg::CMD_PLAIN_CHAR,
                          last_plain ^ ($urandom_range(1) ? 8'h20 : 8'h00));
            else if (r < 91)
                send_word(plf_pkg::CMD_PLAIN_CHAR, rand_byte());
            else if (r < 95)
                send_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), rand_byte());
            else if (r < 98)
                send_word(plf_pkg::CMD_KEY_CHAR, rand_letter());
            else
                send_word(plf_pkg::CMD_START_KEY, rand_byte());
        end
    endtask

    task automatic run_session();
        int unsigned n;
        if ($urandom_range(9) != 0)
            send_word(plf_pkg::CMD_START_KEY, rand_byte());
        n = $urandom_range(0, 30);
        for (int k = 0; k < n; k++)
            send_word(plf_pkg::CMD_KEY_CHAR,
                      ($urandom_range(4) == 0) ? rand_byte() : rand_letter());
        // enciphering with the key still open reads the last key's square, as rewritten so far
        if ($urandom_range(9) == 0)
            send_message($urandom_range(1, 4));
        send_word(plf_pkg::CMD_CLOSE_KEY, rand_byte());
        if ($urandom_range(6) == 0)
            send_word(plf_pkg::CMD_CLOSE_KEY, rand_byte());
        send_message($urandom_range(1, 24));
        if ($urandom_range(9) != 0)
            send_word(plf_pkg::CMD_END_MSG, rand_byte());
        if ($urandom_range(7) == 0)
            send_word(plf_pkg::CMD_END_MSG, rand_byte());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // key: J folds to I, repeats and non-letters dropped, close given twice
        send_word(plf_pkg::CMD_START_KEY, 8'h00);
        send_word(plf_pkg::CMD_KEY_CHAR, "j");
        send_word(plf_pkg::CMD_KEY_CHAR, "Z");
        send_word(plf_pkg::CMD_KEY_CHAR, "a");
        send_word(plf_pkg::CMD_KEY_CHAR, "Z");
        send_word(plf_pkg::CMD_KEY_CHAR, "1");
        send_word(plf_pkg::CMD_KEY_CHAR, 8'hFF);
        send_word(plf_pkg::CMD_CLOSE_KEY, 8'h00);
        send_word(plf_pkg::CMD_CLOSE_KEY, 8'hFF);
        // same row, same column, rectangle
        send_word(plf_pkg::CMD_PLAIN_CHAR, "a");
        send_word(plf_pkg::CMD_PLAIN_CHAR, "z");
        send_word(plf_pkg::CMD_PLAIN_CHAR, "j");
        send_word(plf_pkg::CMD_PLAIN_CHAR, "d");
        send_word(plf_pkg::CMD_PLAIN_CHAR, "E");
        send_word(plf_pkg::CMD_PLAIN_CHAR, "K");
        // doubled X, then padded tail
        send_word(plf_pkg::CMD_PLAIN_CHAR, "X");
        send_word(plf_pkg::CMD_PLAIN_CHAR, "X");
        send_word(plf_pkg::CMD_END_MSG, 8'h00);
        // doubled letter, padded tail, end with nothing held
        send_word(plf_pkg::CMD_PLAIN_CHAR, "L");
        send_word(plf_pkg::CMD_PLAIN_CHAR, "l");
        send_word(plf_pkg::CMD_END_MSG, 8'hFF);
        send_word(plf_pkg::CMD_END_MSG, 8'h00);
        send_word(CMD_SPARE_LO, "Q");
        send_word(CMD_SPARE_HI, 8'h00);
        send_word(plf_pkg::CMD_PLAIN_CHAR, "~");

        while (sb.words_in < ITEMS)
        begin
            calm <= (sb.words_in >= 150) && (sb.words_in < 260);
            run_session();
        end
        item_valid <= 1'b0;
        calm       <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d of them effective, %0d keys closed",
                 sb.words_in, sb.live_words, sb.keys_closed);
        $display("%0d pairs enciphered, %0d cipher letters checked",
                 sb.pairs_made, sb.letters_checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
